@@ rtl/utf8s_pkg.sv @@
// utf8s_pkg: shared types, byte constants and lead-byte helpers for the utf8 sanitizer
// no dependencies; used by utf8s_ifs.sv, utf8_stream_sanitizer.sv, utf8s_clean_checker.sv and the testbench
package utf8s_pkg;

   localparam int ByteW   = 8;
   localparam int RunMax  = 4;
   localparam int RunCntW = $clog2(RunMax + 1);

   typedef logic [ByteW-1:0]   utf8s_byte_type;
   typedef logic [RunCntW-1:0] utf8s_cnt_type;

   localparam logic           OpData  = 1'b0;
   localparam logic           OpFlush = 1'b1;

   localparam utf8s_byte_type ReplByte  = 8'h3F;
   localparam utf8s_byte_type AsciiTop  = 8'h80;
   localparam utf8s_byte_type LeadMin   = 8'hC2;
   localparam utf8s_byte_type LeadMax   = 8'hF4;
   localparam utf8s_byte_type Lead3Min  = 8'hE0;
   localparam utf8s_byte_type Lead4Min  = 8'hF0;
   localparam utf8s_byte_type LeadSurr  = 8'hED;
   localparam utf8s_byte_type ContMask  = 8'hC0;
   localparam utf8s_byte_type ContTag   = 8'h80;
   localparam utf8s_byte_type E0SecMin  = 8'hA0;
   localparam utf8s_byte_type EDSecLim  = 8'hA0;
   localparam utf8s_byte_type F0SecMin  = 8'h90;
   localparam utf8s_byte_type F4SecLim  = 8'h90;

   function automatic logic is_cont(input utf8s_byte_type b);
      return (b & ContMask) == ContTag;
   endfunction

   // continuation bytes still needed after the second byte
   function automatic logic [1:0] extra_need(input utf8s_byte_type lead);
      logic [1:0] need;
      if (lead < Lead3Min) begin
         need = 2'd0;
      end else if (lead < Lead4Min) begin
         need = 2'd1;
      end else begin
         need = 2'd2;
      end
      return need;
   endfunction

   function automatic logic second_ok(input utf8s_byte_type lead, input utf8s_byte_type b);
      logic ok;
      ok = is_cont(b);
      if (lead == Lead3Min) begin
         ok = ok && (b >= E0SecMin);
      end else if (lead == LeadSurr) begin
         ok = ok && (b < EDSecLim);
      end else if (lead == Lead4Min) begin
         ok = ok && (b >= F0SecMin);
      end else if (lead == LeadMax) begin
         ok = ok && (b < F4SecLim);
      end
      return ok;
   endfunction

endpackage

@@ rtl/utf8s_ifs.sv @@
// utf8s_req_if and utf8s_rsp_if: valid/ready channels of the utf8 sanitizer
// depends on utf8s_pkg for the byte type
interface utf8s_req_if;
   import utf8s_pkg::*;
   logic           valid;
   logic           ready;
   logic           op;
   utf8s_byte_type in_byte;
   modport source (output valid, output op, output in_byte, input ready);
   modport sink   (input valid, input op, input in_byte, output ready);
endinterface

interface utf8s_rsp_if;
   import utf8s_pkg::*;
   logic           valid;
   logic           ready;
   utf8s_byte_type out_byte;
   logic           last_of_run;
   modport source (output valid, output out_byte, output last_of_run, input ready);
   modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

@@ rtl/utf8_stream_sanitizer.sv @@
// utf8_stream_sanitizer: byte-wise utf8 validator that replaces bad bytes with '?'
// depends on utf8s_pkg and the channel interfaces in utf8s_ifs.sv
//
// req_ch carries one beat per raw byte (op = data) or an end-of-string marker
// (op = flush). rsp_ch gives the cleaned byte stream; last_of_run marks the
// final output beat caused by one request beat. A request beat makes 0 to 4
// output beats: ascii passes through, a multi-byte sequence is held and sent
// whole at its last byte, bad or broken sequences come out as '?'.
// A request beat lands in an input register, is decoded combinationally into a
// run buffer of up to four bytes and drains one beat per cycle while rsp_ch is
// ready; the first output beat is offered from the run buffer, behind the input
// register. One request beat is taken per cycle while every run is at most one
// byte long and rsp_ch takes every beat; a longer run holds the input register
// until its last beat is taken. Beats making no output still pass the decode.
// When rsp_ch stalls, the run buffer and the input register hold and req_ch
// ready drops once both are full. Synchronous reset empties both and drops
// any held sequence.
module utf8_stream_sanitizer (
   input  logic                clock,
   input  logic                reset,
   utf8s_req_if.sink           req_ch,
   utf8s_rsp_if.source         rsp_ch
);
   import utf8s_pkg::*;

   logic           s1_valid_ff, s1_valid_in;
   logic           s1_op_ff;
   utf8s_byte_type s1_byte_ff;

   utf8s_byte_type lead_held_ff, lead_held_in;
   logic           pending_ff, pending_in;
   utf8s_byte_type cont_ff [2];
   utf8s_byte_type cont_in [2];
   logic [1:0]     cont_cnt_ff, cont_cnt_in;

   utf8s_byte_type run_ff [RunMax];
   utf8s_byte_type run_in [RunMax];
   utf8s_cnt_type  run_cnt_ff, run_cnt_in;

   utf8s_byte_type gen_bytes [RunMax];
   utf8s_cnt_type  gen_cnt;
   utf8s_byte_type gen_lead;
   logic           gen_pending;
   utf8s_byte_type gen_cont [2];
   logic [1:0]     gen_cnt_cont;

   logic req_take;
   logic pop;
   logic s1_adv;

   assign pop      = rsp_ch.valid && rsp_ch.ready;
   assign s1_adv   = s1_valid_ff &&
                     ((run_cnt_ff == '0) || ((run_cnt_ff == utf8s_cnt_type'(1)) && pop));
   assign req_take = req_ch.valid && req_ch.ready;

   assign req_ch.ready       = !s1_valid_ff || s1_adv;
   assign rsp_ch.valid       = run_cnt_ff != '0;
   assign rsp_ch.out_byte    = run_ff[0];
   assign rsp_ch.last_of_run = run_cnt_ff == utf8s_cnt_type'(1);

   // decode of the held item against the sequence state
   always_comb begin
      utf8s_cnt_type nq;
      logic          as_lead;
      logic          ok;
      for (int i = 0; i < RunMax; i++) begin
         gen_bytes[i] = ReplByte;
      end
      gen_cnt      = '0;
      gen_lead     = lead_held_ff;
      gen_pending  = pending_ff;
      gen_cont     = cont_ff;
      gen_cnt_cont = cont_cnt_ff;
      as_lead      = 1'b0;
      ok           = 1'b0;
      nq           = pending_ff ? utf8s_cnt_type'(cont_cnt_ff) + utf8s_cnt_type'(1) : '0;

      if (s1_op_ff == OpFlush) begin
         gen_cnt      = nq;
         gen_pending  = 1'b0;
         gen_cnt_cont = 2'd0;
      end else begin
         as_lead = 1'b1;
         if (pending_ff) begin
            ok = (cont_cnt_ff == 2'd0) ? second_ok(lead_held_ff, s1_byte_ff)
                                       : is_cont(s1_byte_ff);
            if (ok) begin
               as_lead = 1'b0;
               if (cont_cnt_ff >= extra_need(lead_held_ff)) begin
                  gen_bytes[0] = lead_held_ff;
                  unique case (cont_cnt_ff)
                     2'd0: begin
                        gen_bytes[1] = s1_byte_ff;
                     end
                     2'd1: begin
                        gen_bytes[1] = cont_ff[0];
                        gen_bytes[2] = s1_byte_ff;
                     end
                     default: begin
                        gen_bytes[1] = cont_ff[0];
                        gen_bytes[2] = cont_ff[1];
                        gen_bytes[3] = s1_byte_ff;
                     end
                  endcase
                  gen_cnt      = utf8s_cnt_type'(cont_cnt_ff) + utf8s_cnt_type'(2);
                  gen_pending  = 1'b0;
                  gen_cnt_cont = 2'd0;
               end else begin
                  gen_cont[cont_cnt_ff[0]] = s1_byte_ff;
                  gen_cnt_cont             = cont_cnt_ff + 2'd1;
               end
            end else begin
               gen_cnt      = nq;
               gen_pending  = 1'b0;
               gen_cnt_cont = 2'd0;
            end
         end
         if (as_lead) begin
            priority if (s1_byte_ff < AsciiTop) begin
               gen_bytes[nq[1:0]] = s1_byte_ff;
               gen_cnt            = nq + utf8s_cnt_type'(1);
            end else if ((s1_byte_ff >= LeadMin) && (s1_byte_ff <= LeadMax)) begin
               gen_lead     = s1_byte_ff;
               gen_pending  = 1'b1;
               gen_cnt_cont = 2'd0;
            end else begin
               gen_cnt = nq + utf8s_cnt_type'(1);
            end
         end
      end
   end

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      lead_held_in = lead_held_ff;
      pending_in   = pending_ff;
      cont_in      = cont_ff;
      cont_cnt_in  = cont_cnt_ff;
      run_in       = run_ff;
      run_cnt_in   = run_cnt_ff;

      if (pop) begin
         for (int i = 0; i < RunMax - 1; i++) begin
            run_in[i] = run_ff[i+1];
         end
         run_cnt_in = run_cnt_ff - utf8s_cnt_type'(1);
      end

      if (s1_adv) begin
         s1_valid_in  = 1'b0;
         run_in       = gen_bytes;
         run_cnt_in   = gen_cnt;
         lead_held_in = gen_lead;
         pending_in   = gen_pending;
         cont_in      = gen_cont;
         cont_cnt_in  = gen_cnt_cont;
      end

      if (req_take) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         lead_held_ff <= '0;
         pending_ff   <= 1'b0;
         cont_cnt_ff  <= 2'd0;
         run_cnt_ff   <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         lead_held_ff <= lead_held_in;
         pending_ff   <= pending_in;
         cont_cnt_ff  <= cont_cnt_in;
         run_cnt_ff   <= run_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_op_ff   <= req_ch.op;
         s1_byte_ff <= req_ch.in_byte;
      end
      cont_ff <= cont_in;
      run_ff  <= run_in;
   end

endmodule

@@ sim/utf8s_clean_checker.sv @@
// utf8s_clean_checker: watches both channels of the utf8 sanitizer, predicts the cleaned beats
// and compares them in order; reports a mismatch count and the number of beats still owed
// depends on utf8s_pkg and the channel interfaces in utf8s_ifs.sv
module utf8s_clean_checker (
   input  logic        clock,
   input  logic        reset,
   utf8s_req_if        req_ch,
   utf8s_rsp_if        rsp_ch,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import utf8s_pkg::*;

   typedef struct packed {
      utf8s_byte_type out_byte;
      logic           last_of_run;
   } clean_beat_type;

   utf8s_byte_type held_lead;
   bit             held_valid;
   utf8s_byte_type held_cont [2];
   int             cont_used;
   clean_beat_type expected_beats [$];
   int             mismatch_cnt;

   function automatic bit second_fits(input utf8s_byte_type lead, input utf8s_byte_type b);
      if ((b & ContMask) != ContTag) begin
         return 1'b0;
      end
      case (lead)
         Lead3Min: return b >= E0SecMin;
         LeadSurr: return b < EDSecLim;
         Lead4Min: return b >= F0SecMin;
         LeadMax:  return b < F4SecLim;
         default:  return 1'b1;
      endcase
   endfunction

   function automatic int seq_total(input utf8s_byte_type lead);
      if (lead < Lead3Min) begin
         return 2;
      end else if (lead < Lead4Min) begin
         return 3;
      end
      return 4;
   endfunction

   // works out the cleaned run for one request beat and queues it
   function automatic void predict_beat(input logic op, input utf8s_byte_type b);
      utf8s_byte_type run [4];
      int             n;
      int             i;
      bit             as_lead;
      bit             fits;
      clean_beat_type beat;
      n = 0;
      as_lead = (op == OpData);
      if (op == OpFlush || held_valid) begin
         fits = 1'b0;
         if (op == OpData) begin
            fits = (cont_used == 0) ? second_fits(held_lead, b) : ((b & ContMask) == ContTag);
         end
         if (fits) begin
            as_lead = 1'b0;
            if (cont_used + 2 >= seq_total(held_lead)) begin
               run[n] = held_lead;
               n = n + 1;
               for (i = 0; i < cont_used; i++) begin
                  run[n] = held_cont[i];
                  n = n + 1;
               end
               run[n] = b;
               n = n + 1;
               held_valid = 1'b0;
               cont_used = 0;
            end else begin
               held_cont[cont_used] = b;
               cont_used = cont_used + 1;
            end
         end else begin
            if (held_valid) begin
               for (i = 0; i <= cont_used; i++) begin
                  run[n] = ReplByte;
                  n = n + 1;
               end
            end
            held_valid = 1'b0;
            cont_used = 0;
         end
      end
      if (as_lead) begin
         if (b < AsciiTop) begin
            run[n] = b;
            n = n + 1;
         end else if (b >= LeadMin && b <= LeadMax) begin
            held_lead = b;
            held_valid = 1'b1;
            cont_used = 0;
         end else begin
            run[n] = ReplByte;
            n = n + 1;
         end
      end
      for (i = 0; i < n; i++) begin
         beat.out_byte = run[i];
         beat.last_of_run = (i == n - 1);
         expected_beats = {expected_beats, beat};
      end
   endfunction

   always @(posedge clock) begin
      clean_beat_type got;
      clean_beat_type want;
      if (reset) begin
         held_lead = '0;
         held_valid = 1'b0;
         cont_used = 0;
         expected_beats.delete();
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predict_beat(req_ch.op, req_ch.in_byte);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.out_byte = rsp_ch.out_byte;
            got.last_of_run = rsp_ch.last_of_run;
            if (expected_beats.size() == 0) begin
               mismatch_cnt = mismatch_cnt + 1;
               if (mismatch_cnt <= 10) begin
                  $display("%0t: unexpected beat byte %02h last %0b",
                           $realtime, got.out_byte, got.last_of_run);
               end
            end else begin
               want = expected_beats.pop_front();
               if (got.out_byte !== want.out_byte || got.last_of_run !== want.last_of_run) begin
                  mismatch_cnt = mismatch_cnt + 1;
                  if (mismatch_cnt <= 10) begin
                     $display("%0t: mismatch expected byte %02h last %0b, got byte %02h last %0b",
                              $realtime, want.out_byte, want.last_of_run,
                              got.out_byte, got.last_of_run);
                  end
               end
            end
         end
      end
      pending <= expected_beats.size();
      fail_count <= mismatch_cnt;
   end

endmodule

@@ sim/utf8_stream_sanitizer_tb.sv @@
// utf8_stream_sanitizer_tb: drives raw string beats and end-of-string markers into the
// sanitizer with random gaps and output stalls, and gives the verdict from the checker
// depends on utf8s_pkg, utf8s_ifs.sv, utf8_stream_sanitizer and utf8s_clean_checker
module utf8_stream_sanitizer_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import utf8s_pkg::*;

   typedef struct packed {
      logic           op;
      utf8s_byte_type in_byte;
   } raw_beat_type;

   logic         clock;
   logic         reset;
   int           fail_count;
   int           pending;
   bit           calm_tail;
   raw_beat_type raw_beats [$];

   utf8s_req_if req_ch ();
   utf8s_rsp_if rsp_ch ();

   utf8_stream_sanitizer dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   utf8s_clean_checker clean_check (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #200_000;
      $display("FAIL utf8_stream_sanitizer");
      $finish;
   end

   function automatic void add_beat(input logic op, input utf8s_byte_type b);
      raw_beat_type item;
      item.op = op;
      item.in_byte = b;
      raw_beats = {raw_beats, item};
   endfunction

   // well-formed sequence of len bytes, only the first keep of them queued
   function automatic void add_sequence(input int len, input int keep);
      utf8s_byte_type seq_bytes [4];
      int             i;
      case (len)
         1: seq_bytes[0] = utf8s_byte_type'($urandom_range(0, 8'h7F));
         2: seq_bytes[0] = utf8s_byte_type'($urandom_range(8'hC2, 8'hDF));
         3: seq_bytes[0] = utf8s_byte_type'($urandom_range(8'hE0, 8'hEF));
         default: seq_bytes[0] = utf8s_byte_type'($urandom_range(8'hF0, 8'hF4));
      endcase
      for (i = 1; i < len; i++) begin
         seq_bytes[i] = utf8s_byte_type'($urandom_range(8'h80, 8'hBF));
      end
      if (len > 1) begin
         case (seq_bytes[0])
            Lead3Min: seq_bytes[1] = utf8s_byte_type'($urandom_range(8'hA0, 8'hBF));
            LeadSurr: seq_bytes[1] = utf8s_byte_type'($urandom_range(8'h80, 8'h9F));
            Lead4Min: seq_bytes[1] = utf8s_byte_type'($urandom_range(8'h90, 8'hBF));
            LeadMax:  seq_bytes[1] = utf8s_byte_type'($urandom_range(8'h80, 8'h8F));
            default: ;
         endcase
      end
      for (i = 0; i < keep; i++) begin
         add_beat(OpData, seq_bytes[i]);
      end
   endfunction

   task automatic push_beat(input raw_beat_type item);
      req_ch.valid <= 1'b1;
      req_ch.op <= item.op;
      req_ch.in_byte <= item.in_byte;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (pending != 0) begin
         @(posedge clock);
      end
   endtask

   // output stalls in bursts
   initial begin
      int gap;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) begin
         @(posedge clock);
      end
      forever begin
         if (!calm_tail && $urandom_range(0, 6) == 0) begin
            gap = $urandom_range(1, 5);
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
      end
   end

   initial begin
      int n_directed;
      int pick;
      int len;
      int k;
      int gap;
      reset = 1'b1;
      calm_tail = 1'b0;
      req_ch.valid <= 1'b0;
      req_ch.op <= OpData;
      req_ch.in_byte <= '0;

      // ascii extremes, bad leads and a valid two-byte sequence
      add_beat(OpData, 8'h00);
      add_beat(OpData, 8'h7F);
      add_beat(OpData, 8'h80);
      add_beat(OpData, 8'hC1);
      add_beat(OpData, 8'hF5);
      add_beat(OpData, 8'hFF);
      add_beat(OpData, 8'hC2);
      add_beat(OpData, 8'h80);
      // overlong, surrogate and above-range second bytes, then a valid four-byte sequence
      add_beat(OpData, 8'hE0);
      add_beat(OpData, 8'h9F);
      add_beat(OpData, 8'hED);
      add_beat(OpData, 8'hA0);
      add_beat(OpData, 8'hF4);
      add_beat(OpData, 8'h90);
      add_beat(OpData, 8'hF0);
      add_beat(OpData, 8'h8F);
      add_beat(OpData, 8'hF4);
      add_beat(OpData, 8'h8F);
      add_beat(OpData, 8'hBF);
      add_beat(OpData, 8'hBF);
      // sequence broken after two continuation bytes
      add_beat(OpData, 8'hF1);
      add_beat(OpData, 8'h80);
      add_beat(OpData, 8'h80);
      add_beat(OpData, 8'h41);
      // end of string with a lead held, then with nothing held
      add_beat(OpData, 8'hC3);
      add_beat(OpFlush, 8'hFF);
      add_beat(OpFlush, 8'h00);
      n_directed = raw_beats.size();

      while (raw_beats.size() < 150) begin
         pick = $urandom_range(0, 99);
         len = $urandom_range(1, 4);
         if (pick < 60) begin
            add_sequence(len, len);
         end else if (pick < 75) begin
            add_sequence(len, int'($urandom_range(1, len)));
         end else if (pick < 85) begin
            add_beat(OpFlush, utf8s_byte_type'($urandom_range(0, 255)));
         end else begin
            add_beat(OpData, utf8s_byte_type'($urandom_range(0, 255)));
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (k = 0; k < raw_beats.size(); k++) begin
         if (k == raw_beats.size() - 30) begin
            calm_tail = 1'b1;
         end
         if (k == n_directed + 75) begin
            req_ch.valid <= 1'b0;
            wait_drained();
         end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 5);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         push_beat(raw_beats[k]);
      end
      req_ch.valid <= 1'b0;

      wait_drained();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS utf8_stream_sanitizer");
      end else begin
         $display("FAIL utf8_stream_sanitizer");
      end
      $finish;
   end

endmodule
